[sv/sba_pkg.sv]
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and constants for the slab block allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int unsigned SlabCount = 16;
  localparam int unsigned SlabW     = 4;
  localparam int unsigned BlockW    = 8;
  localparam int unsigned HandleW   = SlabW + BlockW;
  localparam int unsigned CountW    = BlockW + 1;
  localparam int unsigned ReturnW   = 5;
  localparam int unsigned NumLists  = 3;

  localparam logic [CountW-1:0] BlocksMax  = CountW'(256);
  localparam logic [CountW-1:0] BpsReset   = CountW'(256);

  // Operation codes.
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_SHRINK  = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // Slab list selectors.
  localparam logic [1:0] L_PART  = 2'd0;
  localparam logic [1:0] L_EMPTY = 2'd1;
  localparam logic [1:0] L_FULL  = 2'd2;

  // One write request into a block link memory.
  typedef struct packed {
    logic               we;
    logic [HandleW-1:0] addr;
    logic [BlockW-1:0]  data;
  } wr_req_t;

endpackage

[sv/sba_if.sv]
// ----------------------------------------------------------------------------
// sba_in_if / sba_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface sba_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [sba_pkg::HandleW-1:0] block_handle;

  modport source (output valid, output operation, output block_handle, input ready);
  modport sink   (input valid, input operation, input block_handle, output ready);
endinterface

interface sba_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [sba_pkg::HandleW-1:0] block_handle_out;
  logic [sba_pkg::ReturnW-1:0] slabs_returned;

  modport source (output valid, output status, output block_handle_out,
                  output slabs_returned, input ready);
  modport sink   (input valid, input status, input block_handle_out,
                  input slabs_returned, output ready);
endinterface

[sv/sba_block_ram.sv]
// ----------------------------------------------------------------------------
// sba_block_ram
// Next and previous links of the per-slab free rings, one shared read address
// with registered read data and an independent write port per array.
// ----------------------------------------------------------------------------
module sba_block_ram (
  input  logic                        clk_i,
  input  logic [sba_pkg::HandleW-1:0] rd_addr_i,
  input  sba_pkg::wr_req_t            nxt_wr_i,
  input  sba_pkg::wr_req_t            prv_wr_i,
  output logic [sba_pkg::BlockW-1:0]  nxt_rdata_o,
  output logic [sba_pkg::BlockW-1:0]  prv_rdata_o
);

  localparam int unsigned Depth = 1 << sba_pkg::HandleW;

  logic [sba_pkg::BlockW-1:0] nxt_mem [Depth];
  logic [sba_pkg::BlockW-1:0] prv_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (nxt_wr_i.we) begin
      nxt_mem[nxt_wr_i.addr] <= nxt_wr_i.data;
    end
    nxt_rdata_o <= nxt_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (prv_wr_i.we) begin
      prv_mem[prv_wr_i.addr] <= prv_wr_i.data;
    end
    prv_rdata_o <= prv_mem[rd_addr_i];
  end

endmodule

[sv/slab_block_allocator.sv]
// ----------------------------------------------------------------------------
// slab_block_allocator
// Slab allocator over sixteen slabs of up to 256 blocks each, kept on partial,
// empty and full slab lists with per-slab circular free rings of blocks.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  in_i     in   valid/ready          operation, block_handle
//  out_o    out  valid/ready          status, block_handle_out, slabs_returned
//  cfg      in   cfg_we_i (no wait)   cfg_data_i = blocks_per_slab
//
// A request beat is taken only while the sequencer is idle; its result goes
// into an output register, so the next beat can be taken while it waits.
// The sequencer returns to idle at the edge that loads the output register.
// Allocate and free walk a chain of slab list updates and may wait on the
// registered read data of the block link memory. Shrink unlinks one empty
// slab per cycle, up to sixteen slabs; release clears all slabs in one state.
// Reset clears the slab flags and list heads at once; there is no clearing
// pass. A stalled result holds the sequencer in its output state.
module slab_block_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sba_in_if.sink                        in_i,
  sba_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [sba_pkg::CountW-1:0]    cfg_data_i
);

  localparam int unsigned SW = sba_pkg::SlabW;
  localparam int unsigned BW = sba_pkg::BlockW;
  localparam int unsigned CW = sba_pkg::CountW;
  localparam int unsigned NS = sba_pkg::SlabCount;
  localparam int unsigned NL = sba_pkg::NumLists;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ASRC   = 4'd1;
  localparam logic [3:0] S_TAKE   = 4'd2;
  localparam logic [3:0] S_TAKERD = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_FCHK   = 4'd5;
  localparam logic [3:0] S_GIVE   = 4'd6;
  localparam logic [3:0] S_GW1    = 4'd7;
  localparam logic [3:0] S_GW2    = 4'd8;
  localparam logic [3:0] S_GPOST  = 4'd9;
  localparam logic [3:0] S_UNL    = 4'd10;
  localparam logic [3:0] S_INSA   = 4'd11;
  localparam logic [3:0] S_INSB   = 4'd12;
  localparam logic [3:0] S_SHR    = 4'd13;
  localparam logic [3:0] S_REL    = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  // Configuration.
  logic [CW-1:0] bps_q;
  logic [CW-1:0] eff;

  // Sequencer control.
  logic [3:0]    state_q, state_d;
  logic [3:0]    ret_q, ret_d;
  logic [1:0]    ul_q, ul_d;
  logic [1:0]    il_q, il_d;
  logic          fpost_q, fpost_d;
  logic [SW-1:0] s_q, s_d;
  logic [BW-1:0] b_q, b_d;
  logic [BW-1:0] n_q, n_d;
  logic [SW-1:0] ln_q, ln_d;
  logic [4:0]    guard_q, guard_d;

  // Result being built and the output register.
  logic [1:0]                  status_q, status_d;
  logic [sba_pkg::HandleW-1:0] hout_q, hout_d;
  logic [sba_pkg::ReturnW-1:0] ret_cnt_q, ret_cnt_d;
  logic                        ov_q, ov_d;
  logic [1:0]                  ost_q;
  logic [sba_pkg::HandleW-1:0] ohd_q;
  logic [sba_pkg::ReturnW-1:0] orc_q;
  logic                        out_load;

  // Slab table.
  logic [NS-1:0] in_use_q, in_use_d;
  logic [NS-1:0] rv_q, rv_d;
  logic [SW-1:0] snext_q [NS];
  logic [SW-1:0] sprev_q [NS];
  logic [CW-1:0] free_q  [NS];
  logic [CW-1:0] expl_q  [NS];
  logic [BW-1:0] rh_q    [NS];
  logic [NL-1:0] hv_q, hv_d;
  logic [SW-1:0] hd_q [NL];
  logic [SW-1:0] hd_d [NL];

  // Slab table write strobes.
  logic          sn_we, sp_we, fr_we, ex_we, rh_we;
  logic [SW-1:0] sn_wa, sn_wd, sp_wa, sp_wd, info_wa;
  logic [CW-1:0] fr_wd, ex_wd;
  logic [BW-1:0] rh_wd;

  // Shared unlink of one slab from a list.
  logic          ul_go;
  logic [1:0]    ul_l;
  logic [SW-1:0] ul_x, ul_n, ul_p;

  // Block link memory.
  sba_pkg::wr_req_t nxt_wr, prv_wr;
  logic [BW-1:0]    bn_rd, bp_rd;

  // Free-slot search and population count.
  logic          lo_found;
  logic [SW-1:0] lo_idx;
  logic [sba_pkg::ReturnW-1:0] pop;

  logic          in_acc;
  logic [SW-1:0] ins_h;
  logic [SW-1:0] ins_n;

  assign eff = (bps_q == '0) ? CW'(1) :
               (bps_q > sba_pkg::BlocksMax) ? sba_pkg::BlocksMax : bps_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid            = ov_q;
  assign out_o.status           = ost_q;
  assign out_o.block_handle_out = ohd_q;
  assign out_o.slabs_returned   = orc_q;

  always_comb begin
    lo_found = 1'b0;
    lo_idx   = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        lo_found = 1'b1;
        lo_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < NS; i++) begin
      pop = pop + sba_pkg::ReturnW'(in_use_q[i]);
    end
  end

  assign ins_h = hd_q[il_q];
  assign ins_n = snext_q[ins_h];
  assign ul_n  = snext_q[ul_x];
  assign ul_p  = sprev_q[ul_x];

  sba_block_ram u_block_ram (
    .clk_i       (clk_i),
    .rd_addr_i   ({s_q, rh_q[s_q]}),
    .nxt_wr_i    (nxt_wr),
    .prv_wr_i    (prv_wr),
    .nxt_rdata_o (bn_rd),
    .prv_rdata_o (bp_rd)
  );

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    ul_d      = ul_q;
    il_d      = il_q;
    fpost_d   = fpost_q;
    s_d       = s_q;
    b_d       = b_q;
    n_d       = n_q;
    ln_d      = ln_q;
    guard_d   = guard_q;
    status_d  = status_q;
    hout_d    = hout_q;
    ret_cnt_d = ret_cnt_q;
    in_use_d  = in_use_q;
    rv_d      = rv_q;
    hv_d      = hv_q;
    hd_d      = hd_q;
    sn_we = 1'b0; sn_wa = '0; sn_wd = '0;
    sp_we = 1'b0; sp_wa = '0; sp_wd = '0;
    fr_we = 1'b0; fr_wd = '0;
    ex_we = 1'b0; ex_wd = '0;
    rh_we = 1'b0; rh_wd = '0;
    info_wa  = s_q;
    ul_go    = 1'b0;
    ul_l     = ul_q;
    ul_x     = s_q;
    nxt_wr   = '0;
    prv_wr   = '0;
    out_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          s_d       = in_i.block_handle[sba_pkg::HandleW-1:BW];
          b_d       = in_i.block_handle[BW-1:0];
          status_d  = sba_pkg::ST_DONE;
          hout_d    = '0;
          ret_cnt_d = '0;
          guard_d   = '0;
          case (in_i.operation)
            sba_pkg::OP_ALLOC:  state_d = S_ASRC;
            sba_pkg::OP_FREE:   state_d = S_FCHK;
            sba_pkg::OP_SHRINK: state_d = S_SHR;
            default:            state_d = S_REL;
          endcase
        end
      end

      S_ASRC: begin
        if (hv_q[sba_pkg::L_PART]) begin
          s_d     = hd_q[sba_pkg::L_PART];
          state_d = S_TAKE;
        end else if (hv_q[sba_pkg::L_EMPTY]) begin
          s_d     = hd_q[sba_pkg::L_EMPTY];
          ul_d    = sba_pkg::L_EMPTY;
          il_d    = sba_pkg::L_PART;
          ret_d   = S_TAKE;
          state_d = S_UNL;
        end else if (lo_found) begin
          // Fresh slab: the lowest free slot, with a clean block account.
          s_d              = lo_idx;
          info_wa          = lo_idx;
          in_use_d[lo_idx] = 1'b1;
          rv_d[lo_idx]     = 1'b0;
          fr_we = 1'b1; fr_wd = eff;
          ex_we = 1'b1; ex_wd = '0;
          rh_we = 1'b1; rh_wd = '0;
          il_d    = sba_pkg::L_PART;
          ret_d   = S_TAKE;
          state_d = S_INSA;
        end else begin
          status_d = sba_pkg::ST_FAIL;
          state_d  = S_OUT;
        end
      end

      S_TAKE: begin
        if (rv_q[s_q]) begin
          // Ring head is being read this cycle.
          b_d     = rh_q[s_q];
          state_d = S_TAKERD;
        end else if (expl_q[s_q] < eff) begin
          ex_we = 1'b1; ex_wd = expl_q[s_q] + CW'(1);
          if (free_q[s_q] != '0) begin
            fr_we = 1'b1; fr_wd = free_q[s_q] - CW'(1);
          end
          hout_d  = {s_q, expl_q[s_q][BW-1:0]};
          state_d = S_CHK;
        end else begin
          status_d = sba_pkg::ST_FAIL;
          state_d  = S_CHK;
        end
      end

      S_TAKERD: begin
        if (bn_rd == b_q) begin
          rv_d[s_q] = 1'b0;
        end else begin
          nxt_wr = '{we: 1'b1, addr: {s_q, bp_rd}, data: bn_rd};
          prv_wr = '{we: 1'b1, addr: {s_q, bn_rd}, data: bp_rd};
          rh_we = 1'b1; rh_wd = bn_rd;
        end
        if (free_q[s_q] != '0) begin
          fr_we = 1'b1; fr_wd = free_q[s_q] - CW'(1);
        end
        hout_d  = {s_q, b_q};
        state_d = S_CHK;
      end

      S_CHK: begin
        if (free_q[s_q] == '0 && hv_q[sba_pkg::L_PART] &&
            hd_q[sba_pkg::L_PART] == s_q) begin
          ul_d    = sba_pkg::L_PART;
          il_d    = sba_pkg::L_FULL;
          ret_d   = S_OUT;
          state_d = S_UNL;
        end else begin
          state_d = S_OUT;
        end
      end

      S_FCHK: begin
        if (!in_use_q[s_q] || {1'b0, b_q} >= expl_q[s_q] || free_q[s_q] >= eff) begin
          status_d = sba_pkg::ST_IGNORED;
          state_d  = S_OUT;
        end else if (free_q[s_q] == '0) begin
          // Full slab goes back to the partial list, then takes the block.
          fpost_d = 1'b0;
          ul_d    = sba_pkg::L_FULL;
          il_d    = sba_pkg::L_PART;
          ret_d   = S_GIVE;
          state_d = S_UNL;
        end else begin
          fpost_d = 1'b1;
          state_d = S_GIVE;
        end
      end

      S_GIVE: begin
        if (!rv_q[s_q]) begin
          nxt_wr = '{we: 1'b1, addr: {s_q, b_q}, data: b_q};
          prv_wr = '{we: 1'b1, addr: {s_q, b_q}, data: b_q};
          rh_we = 1'b1; rh_wd = b_q;
          rv_d[s_q] = 1'b1;
          fr_we = 1'b1; fr_wd = free_q[s_q] + CW'(1);
          state_d = S_GPOST;
        end else begin
          // Successor of the ring head arrives next cycle.
          state_d = S_GW1;
        end
      end

      S_GW1: begin
        nxt_wr = '{we: 1'b1, addr: {s_q, b_q}, data: bn_rd};
        prv_wr = '{we: 1'b1, addr: {s_q, b_q}, data: rh_q[s_q]};
        n_d     = bn_rd;
        state_d = S_GW2;
      end

      S_GW2: begin
        nxt_wr = '{we: 1'b1, addr: {s_q, rh_q[s_q]}, data: b_q};
        prv_wr = '{we: 1'b1, addr: {s_q, n_q}, data: b_q};
        rh_we = 1'b1; rh_wd = b_q;
        rv_d[s_q] = 1'b1;
        fr_we = 1'b1; fr_wd = free_q[s_q] + CW'(1);
        state_d = S_GPOST;
      end

      S_GPOST: begin
        if (fpost_q && free_q[s_q] == eff) begin
          ul_d    = sba_pkg::L_PART;
          il_d    = sba_pkg::L_EMPTY;
          ret_d   = S_OUT;
          state_d = S_UNL;
        end else begin
          state_d = S_OUT;
        end
      end

      S_UNL: begin
        ul_go   = 1'b1;
        state_d = S_INSA;
      end

      S_INSA: begin
        if (!hv_q[il_q]) begin
          sn_we = 1'b1; sn_wa = s_q; sn_wd = s_q;
          sp_we = 1'b1; sp_wa = s_q; sp_wd = s_q;
          hv_d[il_q] = 1'b1;
          hd_d[il_q] = s_q;
          state_d    = ret_q;
        end else begin
          sn_we = 1'b1; sn_wa = s_q; sn_wd = ins_n;
          sp_we = 1'b1; sp_wa = s_q; sp_wd = ins_h;
          ln_d    = ins_n;
          state_d = S_INSB;
        end
      end

      S_INSB: begin
        sn_we = 1'b1; sn_wa = ins_h; sn_wd = s_q;
        sp_we = 1'b1; sp_wa = ln_q;  sp_wd = s_q;
        hd_d[il_q] = s_q;
        hv_d[il_q] = 1'b1;
        state_d    = ret_q;
      end

      S_SHR: begin
        if (guard_q < 5'(NS) && hv_q[sba_pkg::L_EMPTY]) begin
          ul_go = 1'b1;
          ul_l  = sba_pkg::L_EMPTY;
          ul_x  = hd_q[sba_pkg::L_EMPTY];
          if (in_use_q[ul_x]) begin
            in_use_d[ul_x] = 1'b0;
            ret_cnt_d      = ret_cnt_q + 5'd1;
          end
          guard_d = guard_q + 5'd1;
        end else begin
          hv_d[sba_pkg::L_EMPTY] = 1'b0;
          hd_d[sba_pkg::L_EMPTY] = '0;
          state_d = S_OUT;
        end
      end

      S_REL: begin
        ret_cnt_d = pop;
        in_use_d  = '0;
        hv_d      = '0;
        for (int i = 0; i < NL; i++) begin
          hd_d[i] = '0;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!ov_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // Unlink: the list head moves to the successor, or the list empties.
    if (ul_go) begin
      if (ul_n == ul_x) begin
        hv_d[ul_l] = 1'b0;
        hd_d[ul_l] = '0;
      end else begin
        sn_we = 1'b1; sn_wa = ul_p; sn_wd = ul_n;
        sp_we = 1'b1; sp_wa = ul_n; sp_wd = ul_p;
        hd_d[ul_l] = ul_n;
      end
    end
  end

  // Output register: the result beat waits here while new work proceeds.
  always_comb begin
    ov_d = ov_q && !out_o.ready;
    if (out_load) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ov_q     <= 1'b0;
      bps_q    <= sba_pkg::BpsReset;
      in_use_q <= '0;
      rv_q     <= '0;
      hv_q     <= '0;
      for (int i = 0; i < NL; i++) begin
        hd_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      ov_q     <= ov_d;
      in_use_q <= in_use_d;
      rv_q     <= rv_d;
      hv_q     <= hv_d;
      hd_q     <= hd_d;
      if (cfg_we_i) begin
        bps_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q     <= ret_d;
    ul_q      <= ul_d;
    il_q      <= il_d;
    fpost_q   <= fpost_d;
    s_q       <= s_d;
    b_q       <= b_d;
    n_q       <= n_d;
    ln_q      <= ln_d;
    guard_q   <= guard_d;
    status_q  <= status_d;
    hout_q    <= hout_d;
    ret_cnt_q <= ret_cnt_d;
    if (out_load) begin
      ost_q <= status_q;
      ohd_q <= hout_q;
      orc_q <= ret_cnt_q;
    end
    if (sn_we) begin
      snext_q[sn_wa] <= sn_wd;
    end
    if (sp_we) begin
      sprev_q[sp_wa] <= sp_wd;
    end
    if (fr_we) begin
      free_q[info_wa] <= fr_wd;
    end
    if (ex_we) begin
      expl_q[info_wa] <= ex_wd;
    end
    if (rh_we) begin
      rh_q[info_wa] <= rh_wd;
    end
  end

endmodule

[tb/slab_block_allocator_tb.sv]
// ----------------------------------------------------------------------------
// slab_block_allocator_tb
// Drives allocate, free, shrink and release beats into the slab allocator,
// predicts every result with a behavioral slab/ring model, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module slab_block_allocator_tb;

  localparam int NSLAB = 16;
  localparam int NBLK  = 256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sba_pkg::CountW-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  sba_in_if  in_ch ();
  sba_out_if out_ch ();

  slab_block_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  typedef struct packed {
    logic [1:0]                  op;
    logic [sba_pkg::HandleW-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [sba_pkg::HandleW-1:0] handle;
    logic [sba_pkg::ReturnW-1:0] returned;
  } res_t;

  // Shadow of the allocator state.
  int  bps;
  bit  in_use [NSLAB];
  int  s_next [NSLAB];
  int  s_prev [NSLAB];
  int  free_cnt [NSLAB];
  int  carved [NSLAB];
  int  ring_head [NSLAB];
  bit  ring_ok [NSLAB];
  int  b_next [NSLAB*NBLK];
  int  b_prev [NSLAB*NBLK];
  bit  head_ok [3];
  int  head [3];
  // Handles currently handed out, used to build legal frees.
  int  live [$];

  req_t pending [$];
  res_t expected [$];
  int   errors = 0;
  int   mismatches = 0;
  bit   hold_req = 1'b0;
  bit   hold_off = 1'b0;
  bit   in_fire = 1'b0;

  function automatic int blocks_eff();
    if (bps == 0) return 1;
    if (bps > NBLK) return NBLK;
    return bps;
  endfunction

  function automatic void list_push(int l, int s);
    int n;
    if (!head_ok[l]) begin
      s_next[s] = s;
      s_prev[s] = s;
    end else begin
      n = s_next[head[l]];
      s_next[s] = n;
      s_prev[s] = head[l];
      s_next[head[l]] = s;
      s_prev[n] = s;
    end
    head_ok[l] = 1'b1;
    head[l] = s;
  endfunction

  // Unlinking advances the list head to the successor.
  function automatic void list_pull(int l, int s);
    int n, p;
    n = s_next[s];
    if (n == s) begin
      head_ok[l] = 1'b0;
      head[l] = 0;
    end else begin
      p = s_prev[s];
      s_next[p] = n;
      s_prev[n] = p;
      head_ok[l] = 1'b1;
      head[l] = n;
    end
  endfunction

  function automatic bit take_block(int s, output int b);
    int n, p;
    if (ring_ok[s]) begin
      b = ring_head[s];
      n = b_next[s*NBLK+b];
      if (n == b) ring_ok[s] = 1'b0;
      else begin
        p = b_prev[s*NBLK+b];
        b_next[s*NBLK+p] = n;
        b_prev[s*NBLK+n] = p;
        ring_head[s] = n;
      end
      if (free_cnt[s] > 0) free_cnt[s]--;
      return 1'b1;
    end
    if (carved[s] < blocks_eff()) begin
      b = carved[s];
      carved[s]++;
      if (free_cnt[s] > 0) free_cnt[s]--;
      return 1'b1;
    end
    b = 0;
    return 1'b0;
  endfunction

  function automatic void give_block(int s, int b);
    int h, n;
    if (!ring_ok[s]) begin
      b_next[s*NBLK+b] = b;
      b_prev[s*NBLK+b] = b;
    end else begin
      h = ring_head[s];
      n = b_next[s*NBLK+h];
      b_prev[s*NBLK+b] = h;
      b_next[s*NBLK+b] = n;
      b_next[s*NBLK+h] = b;
      b_prev[s*NBLK+n] = b;
    end
    ring_head[s] = b;
    ring_ok[s] = 1'b1;
    free_cnt[s]++;
  endfunction

  function automatic void drop_live_slab(int s);
    for (int i = live.size() - 1; i >= 0; i--)
      if (live[i] / NBLK == s) live.delete(i);
  endfunction

  // Computes the result of one accepted request and updates the shadow state.
  function automatic res_t predict_allocator(req_t r);
    res_t o;
    int s, b, sl, bl;
    bit have;
    o = '0;
    s = 0;
    b = 0;
    case (r.op)
      sba_pkg::OP_ALLOC: begin
        have = 1'b1;
        if (head_ok[sba_pkg::L_PART]) s = head[sba_pkg::L_PART];
        else if (head_ok[sba_pkg::L_EMPTY]) begin
          s = head[sba_pkg::L_EMPTY];
          list_pull(sba_pkg::L_EMPTY, s);
          list_push(sba_pkg::L_PART, s);
        end else begin
          have = 1'b0;
          for (int i = 0; i < NSLAB; i++)
            if (!have && !in_use[i]) begin
              s = i;
              have = 1'b1;
            end
          if (have) begin
            in_use[s] = 1'b1;
            free_cnt[s] = blocks_eff();
            carved[s] = 0;
            ring_head[s] = 0;
            ring_ok[s] = 1'b0;
            list_push(sba_pkg::L_PART, s);
          end
        end
        if (have && take_block(s, b)) begin
          o.handle = sba_pkg::HandleW'(s*NBLK + b);
          live.push_back(s*NBLK + b);
        end else o.status = sba_pkg::ST_FAIL;
        if (have && free_cnt[s] == 0 && head_ok[sba_pkg::L_PART] &&
            head[sba_pkg::L_PART] == s) begin
          list_pull(sba_pkg::L_PART, s);
          list_push(sba_pkg::L_FULL, s);
        end
      end
      sba_pkg::OP_FREE: begin
        sl = r.handle / NBLK;
        bl = r.handle % NBLK;
        if (!in_use[sl] || bl >= carved[sl] || free_cnt[sl] >= blocks_eff())
          o.status = sba_pkg::ST_IGNORED;
        else begin
          for (int i = 0; i < live.size(); i++)
            if (live[i] == int'(r.handle)) begin
              live.delete(i);
              break;
            end
          if (free_cnt[sl] == 0) begin
            list_pull(sba_pkg::L_FULL, sl);
            give_block(sl, bl);
            list_push(sba_pkg::L_PART, sl);
          end else begin
            give_block(sl, bl);
            if (free_cnt[sl] == blocks_eff()) begin
              list_pull(sba_pkg::L_PART, sl);
              list_push(sba_pkg::L_EMPTY, sl);
            end
          end
        end
      end
      sba_pkg::OP_SHRINK: begin
        for (int g = 0; g < NSLAB && head_ok[sba_pkg::L_EMPTY]; g++) begin
          s = head[sba_pkg::L_EMPTY];
          list_pull(sba_pkg::L_EMPTY, s);
          if (in_use[s]) begin
            in_use[s] = 1'b0;
            o.returned++;
            drop_live_slab(s);
          end
        end
        head_ok[sba_pkg::L_EMPTY] = 1'b0;
      end
      default: begin
        for (int i = 0; i < NSLAB; i++)
          if (in_use[i]) begin
            in_use[i] = 1'b0;
            o.returned++;
          end
        live.delete();
        for (int l = 0; l < 3; l++) head_ok[l] = 1'b0;
      end
    endcase
    return o;
  endfunction

  // Driver: one beat per pending entry, with random gaps between beats. A beat
  // stays on offer until the monitor has seen it accepted.
  int gap = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= sba_pkg::OP_ALLOC;
      in_ch.block_handle <= '0;
    end else if (in_ch.valid && !in_fire) begin
      // Beat still on offer; leave it alone.
    end else if (gap > 0) begin
      gap <= gap - 1;
      in_ch.valid <= 1'b0;
    end else if (pending.size() > 0) begin
      req_t r;
      r = pending.pop_front();
      in_ch.valid <= 1'b1;
      in_ch.operation <= r.op;
      in_ch.block_handle <= r.handle;
      gap <= ($urandom_range(0, 3) == 0) ? 0 :
             ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
             $urandom_range(0, 2);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Long receiver hold-off, counted here in clock cycles.
  always begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
    wait (!hold_req);
  end

  // Receiver ready, with random stalls and the long hold-off window.
  int stall = 0;
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0)
        stall <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) :
                 $urandom_range(1, 3);
    end
  end

  // Monitor: the prediction is made at the accepting edge of the request.
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_fire)
        expected.push_back(predict_allocator({in_ch.operation, in_ch.block_handle}));
      if (out_ch.valid && out_ch.ready) begin
        res_t got, want;
        got = {out_ch.status, out_ch.block_handle_out, out_ch.slabs_returned};
        if (expected.size() == 0) begin
          errors++;
          if (mismatches < 10)
            $display("ERROR: unexpected result beat %h", got);
          mismatches++;
        end else begin
          want = expected.pop_front();
          if (got !== want) begin
            errors++;
            if (mismatches < 10)
              $display("ERROR: status %0d/%0d handle %h/%h returned %0d/%0d (exp/got)",
                       want.status, got.status, want.handle, got.handle,
                       want.returned, got.returned);
            mismatches++;
          end
        end
      end
    end
  end

  // Stimulus helpers: the pool of live handles is only known after the beats
  // are predicted, so frees pick a handle when queued and may turn out stale;
  // a stale free is still a legal, checked request.
  task automatic queue_beat(logic [1:0] op, int h);
    pending.push_back({op, sba_pkg::HandleW'(h)});
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_ch.valid || expected.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_bps(int v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= sba_pkg::CountW'(v);
    bps = v & 9'h1FF;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_free();
    int r;
    r = $urandom_range(0, 9);
    if (live.size() > 0 && r < 8) return live[$urandom_range(0, live.size() - 1)];
    return $urandom_range(0, 4095);
  endfunction

  // Random phase with a given mix; frees are drawn from what is live now.
  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) queue_beat(sba_pkg::OP_ALLOC, $urandom_range(0, 4095));
      else if (r < 90) queue_beat(sba_pkg::OP_FREE, pick_free());
      else if (r < 97) queue_beat(sba_pkg::OP_SHRINK, $urandom_range(0, 4095));
      else queue_beat(sba_pkg::OP_RELEASE, $urandom_range(0, 4095));
      // Let the shadow catch up so frees target real blocks.
      while (pending.size() > 4) @(posedge clk_i);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLAB; i++) in_use[i] = 1'b0;
    for (int l = 0; l < 3; l++) begin
      head_ok[l] = 1'b0;
      head[l] = 0;
    end
    bps = 256;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single-block slabs so the slab lists fill.
    write_bps(0);
    queue_beat(sba_pkg::OP_FREE, 12'hFFF);
    queue_beat(sba_pkg::OP_ALLOC, 0);
    queue_beat(sba_pkg::OP_ALLOC, 12'hFFF);
    queue_beat(sba_pkg::OP_FREE, 12'h000);
    queue_beat(sba_pkg::OP_FREE, 12'h000);
    queue_beat(sba_pkg::OP_FREE, 12'h101);
    queue_beat(sba_pkg::OP_SHRINK, 0);
    queue_beat(sba_pkg::OP_ALLOC, 0);
    queue_beat(sba_pkg::OP_RELEASE, 0);
    for (int i = 0; i < 17; i++) queue_beat(sba_pkg::OP_ALLOC, 0);
    queue_beat(sba_pkg::OP_FREE, 12'h0F0);
    queue_beat(sba_pkg::OP_RELEASE, 12'hAAA);
    drain();

    // Small slabs with heavy reuse of the free rings.
    write_bps(3);
    random_phase(250);
    drain();
    write_bps(511);
    random_phase(150);

    // Block the receiver so the allocator backs up on its input.
    drain();
    hold_req = 1'b1;
    wait (hold_off);
    for (int i = 0; i < 12; i++) queue_beat(sba_pkg::OP_ALLOC, 0);
    wait (!hold_off);
    hold_req = 1'b0;
    drain();

    write_bps(1);
    random_phase(150);
    drain();
    write_bps(256);
    random_phase(150);
    drain();
    write_bps(257);
    random_phase(100);
    drain();
    write_bps(5);
    random_phase(200);
    drain();

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
sv/sba_pkg.sv
sv/sba_if.sv
sv/sba_block_ram.sv
sv/slab_block_allocator.sv
tb/slab_block_allocator_tb.sv
